FILE: hdl/fmbc_pkg.sv
package fmbc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_BATT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_HOLD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_GAP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL_LONG  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL_SHORT = 3'd4;

    localparam logic [9:0] LOW_BATT_RST     = 10'd300;
    localparam logic [7:0] FLASH_HOLD_RST   = 8'd10;
    localparam logic [7:0] FLASH_GAP_RST    = 8'd30;
    localparam logic [7:0] SIGNAL_LONG_RST  = 8'd60;
    localparam logic [7:0] SIGNAL_SHORT_RST = 8'd10;

    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_KEY  = 2'd1;

    localparam logic [1:0] EV_SINGLE = 2'd1;
    localparam logic [1:0] EV_DOUBLE = 2'd2;

    localparam logic [3:0] PHASE_FIRST_BLUE = 4'd6;
    localparam logic [3:0] PHASE_RED_LAST   = 4'd5;
    localparam logic [3:0] PHASE_LAST       = 4'd11;
    localparam logic [3:0] PHASE_COUNT      = 4'd12;

    typedef enum logic [2:0] {
        MODE_OFF    = 3'd0,
        MODE_WHITE  = 3'd1,
        MODE_RED    = 3'd2,
        MODE_BLUE   = 3'd3,
        MODE_FLASH  = 3'd4,
        MODE_SIGNAL = 3'd5
    } t_mode;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] key_event;
        logic       input_power;
        logic       boost_active;
        logic [9:0] batt_voltage;
    } t_in_item;

    typedef struct packed {
        logic       lamp_white;
        logic       lamp_red;
        logic       lamp_blue;
        logic [2:0] mode;
        logic       charger_key_pulse;
        logic       sleep_request;
    } t_out_item;

endpackage

FILE: hdl/fmbc_if.sv
interface fmbc_in_if;
    import fmbc_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface fmbc_out_if;
    import fmbc_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/flashlight_mode_blink_controller_top.sv
// Channel    | Direction | Payload
// -----------+-----------+------------------------------------------------
// i_item     | in        | kind, key_event, input_power, boost_active, batt
// o_result   | out       | lamp_white, lamp_red, lamp_blue, mode, pulse, sleep
// i_cfg_*    | in        | register index and write data, no read-back
//
// Each transfer on i_item yields one transfer on o_result.
// One item is accepted in each cycle with i_item.ready high; the state update
// is a single pass of next-state logic between the input register and the
// result register. A stalled result holds the result register, then the input
// register; i_item.ready falls only when both are full.
// Reset is synchronous and restores the default register values and mode off.
module flashlight_mode_blink_controller_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    fmbc_in_if.sink                        i_item,
    fmbc_out_if.source                     o_result,
    input  logic                           i_cfg_we,
    input  logic [fmbc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [fmbc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import fmbc_pkg::*;

    logic [9:0] r_low_batt;
    logic [7:0] r_flash_hold;
    logic [7:0] r_flash_gap;
    logic [7:0] r_signal_long;
    logic [7:0] r_signal_short;

    t_mode      r_mode;
    logic       r_white;
    logic       r_red;
    logic       r_blue;
    logic [3:0] r_flash_phase;
    logic [7:0] r_flash_count;
    logic [3:0] r_signal_phase;
    logic [7:0] r_signal_count;

    t_mode      n_mode;
    logic       n_white;
    logic       n_red;
    logic       n_blue;
    logic [3:0] n_flash_phase;
    logic [7:0] n_flash_count;
    logic [3:0] n_signal_phase;
    logic [7:0] n_signal_count;
    logic       n_pulse;
    logic       n_sleep;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;

    logic advance;
    logic low_batt;

    assign advance = !r_out_valid || o_result.ready;
    assign i_item.ready = !r_in_valid || advance;
    assign o_result.valid = r_out_valid;
    assign o_result.data = r_out;

    assign low_batt = (r_in.batt_voltage < r_low_batt) && !r_in.input_power;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_batt     <= LOW_BATT_RST;
            r_flash_hold   <= FLASH_HOLD_RST;
            r_flash_gap    <= FLASH_GAP_RST;
            r_signal_long  <= SIGNAL_LONG_RST;
            r_signal_short <= SIGNAL_SHORT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LOW_BATT:     r_low_batt     <= i_cfg_data;
                CFG_FLASH_HOLD:   r_flash_hold   <= i_cfg_data[7:0];
                CFG_FLASH_GAP:    r_flash_gap    <= i_cfg_data[7:0];
                CFG_SIGNAL_LONG:  r_signal_long  <= i_cfg_data[7:0];
                CFG_SIGNAL_SHORT: r_signal_short <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_mode         = r_mode;
        n_white        = r_white;
        n_red          = r_red;
        n_blue         = r_blue;
        n_flash_phase  = r_flash_phase;
        n_flash_count  = r_flash_count;
        n_signal_phase = r_signal_phase;
        n_signal_count = r_signal_count;
        n_pulse        = 1'b0;
        n_sleep        = 1'b0;

        if (r_in.kind == KIND_KEY) begin
            n_pulse = !r_in.input_power && !r_in.boost_active
                      && (r_in.key_event == EV_SINGLE);
            if (low_batt) begin
                n_mode  = MODE_OFF;
                n_white = 1'b0;
                n_red   = 1'b0;
                n_blue  = 1'b0;
            end else if (r_mode == MODE_OFF) begin
                if (r_in.key_event == EV_DOUBLE) begin
                    n_mode  = MODE_WHITE;
                    n_white = 1'b1;
                end
            end else if (r_in.key_event == EV_SINGLE) begin
                n_white = 1'b0;
                n_red   = 1'b0;
                n_blue  = 1'b0;
                case (r_mode)
                    MODE_WHITE: begin
                        n_mode = MODE_RED;
                        n_red  = 1'b1;
                    end
                    MODE_RED: begin
                        n_mode = MODE_BLUE;
                        n_blue = 1'b1;
                    end
                    MODE_BLUE: begin
                        n_mode        = MODE_FLASH;
                        n_flash_phase = '0;
                        n_flash_count = '0;
                    end
                    MODE_FLASH: begin
                        n_mode         = MODE_SIGNAL;
                        n_signal_phase = '0;
                    end
                    default: begin
                        n_mode  = MODE_WHITE;
                        n_white = 1'b1;
                    end
                endcase
            end else if (r_in.key_event == EV_DOUBLE) begin
                n_mode  = MODE_OFF;
                n_white = 1'b0;
                n_red   = 1'b0;
                n_blue  = 1'b0;
            end
        end else if (r_in.kind == KIND_TICK) begin
            if (!r_in.input_power && !r_in.boost_active && r_mode == MODE_OFF) begin
                n_sleep = 1'b1;
            end else begin
                if (low_batt) begin
                    n_mode  = MODE_OFF;
                    n_white = 1'b0;
                    n_red   = 1'b0;
                    n_blue  = 1'b0;
                end
                if (n_mode == MODE_FLASH) begin
                    if (r_flash_count != '0) begin
                        n_flash_count = r_flash_count - 8'd1;
                    end else if (r_flash_phase < PHASE_FIRST_BLUE) begin
                        n_red         = !r_flash_phase[0];
                        n_flash_count = (r_flash_phase == PHASE_RED_LAST) ?
                                        r_flash_gap : r_flash_hold;
                        n_flash_phase = r_flash_phase + 4'd1;
                    end else if (r_flash_phase < PHASE_COUNT) begin
                        n_blue        = !r_flash_phase[0];
                        n_flash_count = (r_flash_phase == PHASE_LAST) ?
                                        r_flash_gap : r_flash_hold;
                        n_flash_phase = (r_flash_phase == PHASE_LAST) ?
                                        4'd0 : r_flash_phase + 4'd1;
                    end else begin
                        n_red         = 1'b0;
                        n_blue        = 1'b0;
                        n_flash_phase = '0;
                        n_flash_count = '0;
                    end
                end
                if (n_mode == MODE_SIGNAL) begin
                    if (r_signal_count != '0) begin
                        n_signal_count = r_signal_count - 8'd1;
                    end else if (r_signal_phase < PHASE_COUNT) begin
                        n_red          = !r_signal_phase[0];
                        n_signal_count = (r_signal_phase < PHASE_FIRST_BLUE
                                          || r_signal_phase == PHASE_LAST) ?
                                         r_signal_long : r_signal_short;
                        n_signal_phase = (r_signal_phase == PHASE_LAST) ?
                                         4'd0 : r_signal_phase + 4'd1;
                    end else begin
                        n_red          = 1'b0;
                        n_signal_phase = '0;
                        n_signal_count = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_mode         <= MODE_OFF;
            r_white        <= 1'b0;
            r_red          <= 1'b0;
            r_blue         <= 1'b0;
            r_flash_phase  <= '0;
            r_flash_count  <= '0;
            r_signal_phase <= '0;
            r_signal_count <= '0;
        end else begin
            if (i_item.ready) begin
                r_in_valid <= i_item.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_mode         <= n_mode;
                    r_white        <= n_white;
                    r_red          <= n_red;
                    r_blue         <= n_blue;
                    r_flash_phase  <= n_flash_phase;
                    r_flash_count  <= n_flash_count;
                    r_signal_phase <= n_signal_phase;
                    r_signal_count <= n_signal_count;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_in <= i_item.data;
        end
        if (advance && r_in_valid) begin
            r_out.lamp_white        <= n_white;
            r_out.lamp_red          <= n_red;
            r_out.lamp_blue         <= n_blue;
            r_out.mode              <= n_mode;
            r_out.charger_key_pulse <= n_pulse;
            r_out.sleep_request     <= n_sleep;
        end
    end

    a_off_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_OFF |-> !r_white && !r_red && !r_blue)
        else $error("Lamp lit while the mode is off.");

    a_white_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_white |-> r_mode == MODE_WHITE)
        else $error("White lamp lit outside white mode.");

    a_blue_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_blue |-> r_mode == MODE_BLUE || r_mode == MODE_FLASH)
        else $error("Blue lamp lit outside blue and flash modes.");

    a_red_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_red |-> r_mode == MODE_RED || r_mode == MODE_FLASH || r_mode == MODE_SIGNAL)
        else $error("Red lamp lit outside the red modes.");

    a_sleep_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.sleep_request |->
            r_out.mode == MODE_OFF && !r_out.charger_key_pulse)
        else $error("Sleep request with an active mode or a charger pulse.");

endmodule

FILE: test/fmbc_lamp_checker.sv
`timescale 1ns / 1ps

module fmbc_lamp_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    fmbc_in_if                              i_item,
    fmbc_out_if                             i_result,
    input  logic                            i_cfg_we,
    input  logic [fmbc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fmbc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_outstanding,
    output int                              o_mismatches
);
    import fmbc_pkg::*;

    logic [9:0] batt_floor;
    logic [7:0] flash_hold_ticks;
    logic [7:0] flash_gap_ticks;
    logic [7:0] signal_long_ticks;
    logic [7:0] signal_short_ticks;

    t_mode      cur_mode;
    logic       lit_white;
    logic       lit_red;
    logic       lit_blue;
    logic [3:0] flash_step;
    logic [7:0] flash_wait;
    logic [3:0] signal_step;
    logic [7:0] signal_wait;

    t_out_item  lamp_results_due[$];
    int         mismatch_total;

    function automatic t_out_item next_lamp_result(input t_in_item it);
        t_out_item r;
        logic      low_batt;
        logic      pulse;
        logic      sleep;
        low_batt = (it.batt_voltage < batt_floor) && !it.input_power;
        pulse = 1'b0;
        sleep = 1'b0;
        if (it.kind == KIND_KEY) begin
            pulse = !it.input_power && !it.boost_active && (it.key_event == EV_SINGLE);
            if (low_batt) begin
                cur_mode = MODE_OFF;
                {lit_white, lit_red, lit_blue} = 3'b000;
            end else if (cur_mode == MODE_OFF) begin
                if (it.key_event == EV_DOUBLE) begin
                    cur_mode = MODE_WHITE;
                    lit_white = 1'b1;
                end
            end else if (it.key_event == EV_SINGLE) begin
                cur_mode = (cur_mode == MODE_SIGNAL) ? MODE_WHITE : t_mode'(cur_mode + 3'd1);
                {lit_white, lit_red, lit_blue} = 3'b000;
                case (cur_mode)
                    MODE_WHITE: lit_white = 1'b1;
                    MODE_RED:   lit_red = 1'b1;
                    MODE_BLUE:  lit_blue = 1'b1;
                    MODE_FLASH: begin
                        flash_step = '0;
                        flash_wait = '0;
                    end
                    default:    signal_step = '0;
                endcase
            end else if (it.key_event == EV_DOUBLE) begin
                cur_mode = MODE_OFF;
                {lit_white, lit_red, lit_blue} = 3'b000;
            end
        end else if (it.kind == KIND_TICK) begin
            if (!it.input_power && !it.boost_active && cur_mode == MODE_OFF) begin
                sleep = 1'b1;
            end else begin
                if (low_batt) begin
                    cur_mode = MODE_OFF;
                    {lit_white, lit_red, lit_blue} = 3'b000;
                end
                if (cur_mode == MODE_FLASH) begin
                    if (flash_wait != 0) begin
                        flash_wait = flash_wait - 8'd1;
                    end else if (flash_step < PHASE_FIRST_BLUE) begin
                        lit_red = ~flash_step[0];
                        flash_wait = (flash_step == PHASE_RED_LAST) ? flash_gap_ticks
                                                                    : flash_hold_ticks;
                        flash_step = flash_step + 4'd1;
                    end else if (flash_step < PHASE_COUNT) begin
                        lit_blue = ~flash_step[0];
                        flash_wait = (flash_step == PHASE_LAST) ? flash_gap_ticks
                                                                : flash_hold_ticks;
                        flash_step = (flash_step == PHASE_LAST) ? 4'd0 : flash_step + 4'd1;
                    end else begin
                        lit_red = 1'b0;
                        lit_blue = 1'b0;
                        flash_step = '0;
                        flash_wait = '0;
                    end
                end
                if (cur_mode == MODE_SIGNAL) begin
                    if (signal_wait != 0) begin
                        signal_wait = signal_wait - 8'd1;
                    end else if (signal_step < PHASE_COUNT) begin
                        lit_red = ~signal_step[0];
                        signal_wait = (signal_step < PHASE_FIRST_BLUE
                                       || signal_step == PHASE_LAST)
                                      ? signal_long_ticks : signal_short_ticks;
                        signal_step = (signal_step == PHASE_LAST) ? 4'd0 : signal_step + 4'd1;
                    end else begin
                        lit_red = 1'b0;
                        signal_step = '0;
                        signal_wait = '0;
                    end
                end
            end
        end
        r.lamp_white = lit_white;
        r.lamp_red = lit_red;
        r.lamp_blue = lit_blue;
        r.mode = cur_mode;
        r.charger_key_pulse = pulse;
        r.sleep_request = sleep;
        return r;
    endfunction

    function automatic int field_differs(input string name, input logic [2:0] want,
                                         input logic [2:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            batt_floor = LOW_BATT_RST;
            flash_hold_ticks = FLASH_HOLD_RST;
            flash_gap_ticks = FLASH_GAP_RST;
            signal_long_ticks = SIGNAL_LONG_RST;
            signal_short_ticks = SIGNAL_SHORT_RST;
            cur_mode = MODE_OFF;
            {lit_white, lit_red, lit_blue} = 3'b000;
            flash_step = '0;
            flash_wait = '0;
            signal_step = '0;
            signal_wait = '0;
            lamp_results_due.delete();
            mismatch_total = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LOW_BATT:     batt_floor = i_cfg_data;
                    CFG_FLASH_HOLD:   flash_hold_ticks = i_cfg_data[7:0];
                    CFG_FLASH_GAP:    flash_gap_ticks = i_cfg_data[7:0];
                    CFG_SIGNAL_LONG:  signal_long_ticks = i_cfg_data[7:0];
                    CFG_SIGNAL_SHORT: signal_short_ticks = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_result.valid && i_result.ready) begin
                got = i_result.data;
                if (lamp_results_due.size() == 0) begin
                    $display("%0t: result transfer expected none, got %b", $time, got);
                    mismatch_total++;
                end else begin
                    want = lamp_results_due.pop_front();
                    mismatch_total += field_differs("lamp_white", want.lamp_white,
                                                    got.lamp_white);
                    mismatch_total += field_differs("lamp_red", want.lamp_red, got.lamp_red);
                    mismatch_total += field_differs("lamp_blue", want.lamp_blue, got.lamp_blue);
                    mismatch_total += field_differs("mode", want.mode, got.mode);
                    mismatch_total += field_differs("charger_key_pulse",
                                                    want.charger_key_pulse,
                                                    got.charger_key_pulse);
                    mismatch_total += field_differs("sleep_request", want.sleep_request,
                                                    got.sleep_request);
                end
            end
            if (i_item.valid && i_item.ready) begin
                lamp_results_due.push_back(next_lamp_result(i_item.data));
            end
        end
        o_outstanding <= lamp_results_due.size();
        o_mismatches <= mismatch_total;
    end

endmodule

FILE: test/flashlight_mode_blink_controller_top_tb.sv
`timescale 1ns / 1ps

module flashlight_mode_blink_controller_top_tb;
    import fmbc_pkg::*;

    localparam logic [1:0] KIND_OTHER = 2'd2;
    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_SPARE   = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_OFF_CYCLES = 300;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    outstanding;
    int                    mismatches;
    int                    cycle_count = 0;
    int                    hold_off_seq;
    int                    burst_left = 0;
    int                    fed_count = 0;
    logic [9:0]            thr_cur = LOW_BATT_RST;

    fmbc_in_if  item_ch();
    fmbc_out_if result_ch();

    flashlight_mode_blink_controller_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_item     (item_ch),
        .o_result   (result_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    fmbc_lamp_checker checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_item        (item_ch),
        .i_result      (result_ch),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .o_outstanding (outstanding),
        .o_mismatches  (mismatches)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("flashlight_mode_blink_controller_top regression: fail");
            $finish;
        end
    end

    initial begin
        int seen;
        int hold_left;
        int seg_left;
        int stall_pct;
        seen = 0;
        hold_left = 0;
        seg_left = 0;
        stall_pct = 0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off_seq != seen) begin
                seen = hold_off_seq;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(1, 60);
                    case ($urandom_range(0, 4))
                        0, 1:    stall_pct = 0;
                        2:       stall_pct = 25;
                        3:       stall_pct = 60;
                        default: stall_pct = 90;
                    endcase
                end
                seg_left--;
                result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    function automatic t_in_item make_item(input logic [1:0] kind, input logic [1:0] ev,
                                           input logic pwr, input logic boost,
                                           input logic [9:0] batt);
        t_in_item it;
        it.kind = kind;
        it.key_event = ev;
        it.input_power = pwr;
        it.boost_active = boost;
        it.batt_voltage = batt;
        return it;
    endfunction

    function automatic logic [9:0] good_batt();
        return 10'($urandom_range(thr_cur, 1023));
    endfunction

    function automatic logic [9:0] any_batt();
        return 10'($urandom_range(0, 1023));
    endfunction

    function automatic logic [1:0] any_ev();
        return 2'($urandom_range(0, 3));
    endfunction

    function automatic logic coin(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    task automatic send_item(input t_in_item it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        item_ch.valid <= 1'b1;
        item_ch.data <= it;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
        burst_left--;
        fed_count++;
    endtask

    task automatic drain_results();
        item_ch.valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        if (idx == CFG_LOW_BATT) thr_cur = val;
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic [9:0] thr, input logic [7:0] hold,
                                  input logic [7:0] gap, input logic [7:0] lng,
                                  input logic [7:0] sht);
        drain_results();
        write_reg(CFG_LOW_BATT, thr);
        write_reg(CFG_FLASH_HOLD, hold);
        write_reg(CFG_FLASH_GAP, gap);
        write_reg(CFG_SIGNAL_LONG, lng);
        write_reg(CFG_SIGNAL_SHORT, sht);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input int budget, input logic long_hold);
        int start;
        int n;
        logic paused;
        start = fed_count;
        paused = 1'b0;
        if (long_hold) hold_off_seq <= hold_off_seq + 1;
        while (fed_count - start < budget) begin
            if (!paused && fed_count - start >= budget / 2) begin
                drain_results();
                paused = 1'b1;
            end
            if ($urandom_range(0, 9) < 7) begin
                send_item(make_item(KIND_KEY, any_ev(), 1'b0, coin(30), '0));
                send_item(make_item(KIND_KEY, EV_DOUBLE, coin(15), coin(15), good_batt()));
                n = $urandom_range(0, 4);
                repeat (n) begin
                    send_item(make_item(KIND_KEY, EV_SINGLE, coin(15), coin(15), good_batt()));
                end
                n = $urandom_range(4, 70);
                repeat (n) begin
                    if (coin(3)) begin
                        send_item(make_item(2'($urandom_range(0, 3)), any_ev(), coin(50),
                                            coin(50), any_batt()));
                    end else begin
                        send_item(make_item(KIND_TICK, any_ev(), coin(15), coin(15),
                                            coin(95) ? good_batt() : any_batt()));
                    end
                end
            end else begin
                n = $urandom_range(1, 10);
                repeat (n) begin
                    send_item(make_item(2'($urandom_range(0, 3)), any_ev(), coin(50),
                                        coin(50), any_batt()));
                end
            end
        end
    endtask

    initial begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_idx <= '0;
        cfg_data <= '0;
        hold_off_seq <= 0;
        item_ch.valid <= 1'b0;
        item_ch.data <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(make_item(KIND_TICK, EV_NONE, 1'b0, 1'b0, 10'd500));
        send_item(make_item(KIND_KEY, EV_SINGLE, 1'b0, 1'b0, 10'd500));
        send_item(make_item(KIND_KEY, EV_DOUBLE, 1'b0, 1'b0, 10'd0));
        send_item(make_item(KIND_TICK, EV_NONE, 1'b0, 1'b1, 10'd0));
        send_item(make_item(KIND_KEY, EV_DOUBLE, 1'b0, 1'b1, 10'd1023));
        send_item(make_item(KIND_KEY, EV_SINGLE, 1'b1, 1'b0, 10'd0));
        send_item(make_item(KIND_KEY, EV_SINGLE, 1'b0, 1'b0, 10'd300));
        send_item(make_item(KIND_KEY, EV_SINGLE, 1'b0, 1'b0, 10'd301));
        repeat (3) send_item(make_item(KIND_TICK, EV_NONE, 1'b0, 1'b0, 10'd700));
        send_item(make_item(KIND_KEY, EV_NONE, 1'b0, 1'b0, 10'd700));
        send_item(make_item(KIND_KEY, EV_SPARE, 1'b0, 1'b0, 10'd700));
        send_item(make_item(KIND_OTHER, EV_SINGLE, 1'b0, 1'b0, 10'd700));
        send_item(make_item(KIND_SPARE, EV_DOUBLE, 1'b1, 1'b1, 10'd700));
        send_item(make_item(KIND_KEY, EV_SINGLE, 1'b1, 1'b1, 10'd700));
        repeat (2) send_item(make_item(KIND_TICK, EV_NONE, 1'b0, 1'b0, 10'd700));
        send_item(make_item(KIND_KEY, EV_SINGLE, 1'b0, 1'b0, 10'd700));
        send_item(make_item(KIND_TICK, EV_NONE, 1'b1, 1'b0, 10'd0));
        send_item(make_item(KIND_TICK, EV_NONE, 1'b0, 1'b0, 10'd299));
        send_item(make_item(KIND_TICK, EV_NONE, 1'b1, 1'b0, 10'd0));
        send_item(make_item(KIND_KEY, EV_DOUBLE, 1'b0, 1'b0, 10'd1023));
        send_item(make_item(KIND_KEY, EV_DOUBLE, 1'b0, 1'b0, 10'd1023));

        run_phase(120, 1'b1);
        apply_settings(10'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        run_phase(120, 1'b0);
        apply_settings(10'd1023, 8'd255, 8'd255, 8'd255, 8'd255);
        run_phase(60, 1'b0);
        for (int k = 0; k < 4; k++) begin
            apply_settings(10'($urandom_range(0, 700)), 8'($urandom_range(0, 4)),
                           8'($urandom_range(0, 4)), 8'($urandom_range(0, 4)),
                           8'($urandom_range(0, 4)));
            run_phase(115, k == 0);
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (mismatches == 0) begin
            $display("flashlight_mode_blink_controller_top regression: pass");
        end else begin
            $display("flashlight_mode_blink_controller_top regression: fail");
        end
        $finish;
    end

endmodule
